[src/iol_pkg.sv]
// Shared types, codes and constants for the indexed ordered list unit.
package iol_pkg;

  // Field widths fixed by the interface.
  localparam int CMD_W   = 2;
  localparam int POS_W   = 7;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  // Default number of list entries.
  localparam int CAPACITY_DEF = 64;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // Result data selection.
  localparam logic [1:0] DSEL_ZERO  = 2'd0;
  localparam logic [1:0] DSEL_ONES  = 2'd1;
  localparam logic [1:0] DSEL_RDATA = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;          // capture the request word
    logic              cur_init_top;  // cursor to the last entry
    logic              cur_init_pos1; // cursor to the entry after position
    logic              step;          // read at cursor, move one entry, advance
    logic              dir_up;        // shift direction for step
    logic              rd_pos;        // read the entry at position
    logic              put;           // write the new value at position
    logic              cnt_inc;
    logic              cnt_dec;
    logic              emit;          // register a result word
    logic [STAT_W-1:0] emit_status;
    logic [1:0]        emit_dsel;
  } iol_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             pos_gt_count;
    logic             pos_lt_count;
    logic             pos_eq_count;
    logic             pos_is_last;
    logic             full;
    logic             cur_at_pos;
    logic             cur_at_last;
  } iol_sts_t;

endpackage

[src/iol_datapath.sv]
// Datapath of the list unit: request registers, entry memory, count, cursor and result.
module iol_datapath import iol_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [CMD_W-1:0]         command,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] data_in,
  input  iol_ctl_t                 ctl,
  output iol_sts_t                 sts,
  output logic                     done,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] data_out,
  output logic [COUNT_W-1:0]       entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > POS_W) ? CW : POS_W;

  logic [CMD_W-1:0]  cmd_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     count_m1;
  logic [AW-1:0]     cur;
  logic              pend;
  logic [AW-1:0]     pend_addr;
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [MW-1:0]     pos_ext;
  logic [MW-1:0]     pos_p1;
  logic [MW-1:0]     count_ext;
  logic [MW-1:0]     cur_ext;

  // Request word, captured when the controller accepts it.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= command;
      pos_q <= position;
      val_q <= data_in;
    end
  end

  // Position, count and cursor compares for the controller.
  assign pos_ext   = MW'(pos_q);
  assign pos_p1    = pos_ext + MW'(1);
  assign count_ext = MW'(count);
  assign cur_ext   = MW'(cur);
  assign count_m1  = count - CW'(1);

  always_comb begin
    sts.cmd          = cmd_q;
    sts.pos_gt_count = pos_ext > count_ext;
    sts.pos_lt_count = pos_ext < count_ext;
    sts.pos_eq_count = pos_ext == count_ext;
    sts.pos_is_last  = pos_p1 == count_ext;
    sts.full         = count == CW'(CAPACITY);
    sts.cur_at_pos   = cur_ext == pos_ext;
    sts.cur_at_last  = (cur_ext + MW'(1)) == count_ext;
  end

  // Shift cursor walks the entries that move.
  always_ff @(posedge clk) begin
    if (ctl.cur_init_top) begin
      cur <= count_m1[AW-1:0];
    end else if (ctl.cur_init_pos1) begin
      cur <= pos_p1[AW-1:0];
    end else if (ctl.step) begin
      cur <= ctl.dir_up ? cur - AW'(1) : cur + AW'(1);
    end
  end

  // A step reads one entry now and writes it one place over in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= ctl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      pend_addr <= ctl.dir_up ? cur + AW'(1) : cur - AW'(1);
    end
  end

  // Entry memory: one write port, one registered read port.
  assign raddr = ctl.rd_pos ? pos_ext[AW-1:0] : cur;
  assign we    = pend | ctl.put;
  assign waddr = pend ? pend_addr : pos_ext[AW-1:0];
  assign wdata = pend ? rdata : val_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Number of entries held.
  always_comb begin
    priority if (ctl.cnt_inc) begin
      count_next = count + CW'(1);
    end else if (ctl.cnt_dec) begin
      count_next = count_m1;
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result word, shown for one cycle after the controller emits it.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      status      <= ctl.emit_status;
      entry_count <= COUNT_W'(count_next);
      unique case (ctl.emit_dsel)
        DSEL_ONES:  data_out <= '1;
        DSEL_RDATA: data_out <= rdata;
        default:    data_out <= '0;
      endcase
    end
  end

endmodule

[src/iol_ctrl.sv]
// Controller state machine of the list unit: decides each request and sequences shifts.
module iol_ctrl import iol_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  iol_sts_t sts,
  output logic     busy,
  output iol_ctl_t ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_UP    = 3'd2;
  localparam logic [2:0] S_DOWN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_PUT   = 3'd5;
  localparam logic [2:0] S_RD    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next      = state;
    ctl             = '0;
    ctl.emit_status = ST_OK;
    ctl.emit_dsel   = DSEL_ZERO;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (sts.cmd == CMD_INSERT) begin
          priority if (sts.pos_gt_count) begin
            ctl.emit        = 1'b1;
            ctl.emit_status = ST_INVALID;
            state_next      = S_IDLE;
          end else if (sts.full) begin
            ctl.emit        = 1'b1;
            ctl.emit_status = ST_FULL;
            state_next      = S_IDLE;
          end else if (sts.pos_eq_count) begin
            state_next = S_PUT;
          end else begin
            ctl.cur_init_top = 1'b1;
            state_next       = S_UP;
          end
        end else if (sts.cmd == CMD_READ) begin
          if (sts.pos_lt_count) begin
            ctl.rd_pos = 1'b1;
            state_next = S_RD;
          end else begin
            ctl.emit        = 1'b1;
            ctl.emit_status = ST_INVALID;
            ctl.emit_dsel   = DSEL_ONES;
            state_next      = S_IDLE;
          end
        end else if (sts.cmd == CMD_REMOVE) begin
          priority if (!sts.pos_lt_count) begin
            ctl.emit        = 1'b1;
            ctl.emit_status = ST_INVALID;
            state_next      = S_IDLE;
          end else if (sts.pos_is_last) begin
            ctl.cnt_dec = 1'b1;
            ctl.emit    = 1'b1;
            state_next  = S_IDLE;
          end else begin
            ctl.cur_init_pos1 = 1'b1;
            state_next        = S_DOWN;
          end
        end else begin
          ctl.emit        = 1'b1;
          ctl.emit_status = ST_INVALID;
          state_next      = S_IDLE;
        end
      end
      // Move entries up one place, from the last entry down to position.
      S_UP: begin
        ctl.step   = 1'b1;
        ctl.dir_up = 1'b1;
        if (sts.cur_at_pos) begin
          state_next = S_DRAIN;
        end
      end
      // Move entries down one place, from after position up to the last entry.
      S_DOWN: begin
        ctl.step = 1'b1;
        if (sts.cur_at_last) begin
          state_next = S_DRAIN;
        end
      end
      // The last moved entry is written in this cycle.
      S_DRAIN: begin
        if (sts.cmd == CMD_INSERT) begin
          state_next = S_PUT;
        end else begin
          ctl.cnt_dec = 1'b1;
          ctl.emit    = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_PUT: begin
        ctl.put     = 1'b1;
        ctl.cnt_inc = 1'b1;
        ctl.emit    = 1'b1;
        state_next  = S_IDLE;
      end
      S_RD: begin
        ctl.emit      = 1'b1;
        ctl.emit_dsel = DSEL_RDATA;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/indexed_ordered_list_unit.sv]
// Top level of the indexed ordered list unit: controller plus datapath.
// A word is taken when start is high and busy is low; done marks each result for one cycle.
// done follows the evaluate state for bad requests, full inserts and removes of the last
// entry, read or put for reads and end inserts, drain for removes and put for inserts that
// shift entries, one entry per cycle; busy drops as done rises.
// Synchronous reset empties the list and clears done; entry contents are not cleared.
module indexed_ordered_list_unit import iol_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         command,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] data_in,
  output logic                     done,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] data_out,
  output logic [COUNT_W-1:0]       entry_count
);

  iol_ctl_t ctl;
  iol_sts_t sts;

  iol_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  iol_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .position    (position),
    .data_in     (data_in),
    .ctl         (ctl),
    .sts         (sts),
    .done        (done),
    .status      (status),
    .data_out    (data_out),
    .entry_count (entry_count)
  );

endmodule

[src/iol_checker.sv]
// Port-level checker for the indexed ordered list unit, with its bind.
module iol_checker import iol_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic [STAT_W-1:0]        status,
  input logic signed [DATA_W-1:0] data_out,
  input logic [COUNT_W-1:0]       entry_count
);

  // An accepted word keeps the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted word did not raise busy");

  // A result appears only once the unit is free again.
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while busy");

  // A result word follows a busy cycle and is never repeated.
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held for two cycles");

  // A full status only comes with a list holding every entry.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> entry_count == COUNT_W'(CAPACITY))
    else $error("full status with a list that is not full");

  // Data is all ones or zero on any result that is not a good status.
  a_bad_data: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> data_out == '0 || data_out == '1)
    else $error("unexpected data on a failed request");

endmodule

bind indexed_ordered_list_unit iol_checker #(
  .CAPACITY (CAPACITY)
) u_iol_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .data_out    (data_out),
  .entry_count (entry_count)
);
